@@ design/tick_task_scheduler_macros.svh @@
// Assertion macros used by the scheduler datapath.
`ifndef TICK_TASK_SCHEDULER_MACROS_SVH
`define TICK_TASK_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define TTS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TTS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define TTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ design/tts_pkg.sv @@
// Shared types and constants of the tick task scheduler.
package tts_pkg;

  localparam int MAX_TASKS_DEF  = 8;
  localparam int TIME_WIDTH_DEF = 16;

  localparam int SLOT_W   = 4;
  localparam int TAG_W    = 8;
  localparam int FTIME_W  = 16;
  localparam int SEL_W    = 3;
  localparam int PEND_W   = 8;
  localparam int MAX_RES  = 8;
  localparam int CNT_W    = 3;

  localparam logic [PEND_W-1:0] PEND_MAX = 8'd255;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_ADD      = 2'd1,
    OP_DELETE   = 2'd2,
    OP_DISPATCH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DEL
  } state_t;

  typedef enum logic [1:0] {
    RES_ADD,
    RES_FULL,
    RES_DEL,
    RES_RUN
  } res_kind_t;

  typedef struct packed {
    logic      load;
    logic      advance;
    logic      wr_tick;
    logic      wr_add;
    logic      wr_disp;
    logic      del_exec;
    logic      push;
    res_kind_t res_kind;
    logic      res_last;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic at_end;
    logic cur_valid;
    logic cur_runnable;
    logic more_runnable;
    logic cnt_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/tts_datapath.sv @@
// Slot table, scan pointer, request registers and result register.
`include "tick_task_scheduler_macros.svh"

module tts_datapath #(
  parameter int MAX_TASKS  = tts_pkg::MAX_TASKS_DEF,
  parameter int TIME_WIDTH = tts_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    op,
  input  logic [tts_pkg::TAG_W-1:0]     task_tag,
  input  logic [tts_pkg::FTIME_W-1:0]   start_delay,
  input  logic [tts_pkg::FTIME_W-1:0]   repeat_period,
  input  logic [tts_pkg::SEL_W-1:0]     slot_select,
  input  tts_pkg::ctrl_cmd_t            cmd,
  output tts_pkg::dp_status_t           stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tts_pkg::SLOT_W-1:0]    slot_index,
  output logic [tts_pkg::TAG_W-1:0]     run_tag,
  output logic                          run_valid,
  output logic [1:0]                    status,
  output logic                          error_seen,
  output logic                          last
);
  import tts_pkg::*;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  typedef struct packed {
    logic [TAG_W-1:0]      tag;
    logic [TIME_WIDTH-1:0] delay;
    logic [TIME_WIDTH-1:0] period;
    logic [PEND_W-1:0]     pending;
  } entry_t;

  entry_t                mem [MAX_TASKS];
  entry_t                rd_data;
  entry_t                wr_data;
  entry_t                tick_entry;
  entry_t                disp_entry;
  logic                  wr_en;
  logic [IDX_W-1:0]      rd_addr;

  op_t                   op_q;
  logic [TAG_W-1:0]      tag_q;
  logic [TIME_WIDTH-1:0] delay_q;
  logic [TIME_WIDTH-1:0] period_q;
  logic [SEL_W-1:0]      sel_q;
  logic [IDX_W-1:0]      ptr;
  logic [CNT_W-1:0]      cnt;
  logic [MAX_TASKS-1:0]  slot_valid;
  logic [MAX_TASKS-1:0]  runnable;
  logic [MAX_TASKS-1:0]  above;
  logic                  delete_error;

  logic [IDX_W-1:0]      del_idx;
  logic                  del_in_range;
  logic                  del_empty;

  // Read port: slot 0 on load, next slot on advance, same slot again on a stall.
  always_comb begin
    if (cmd.load) begin
      rd_addr = '0;
    end else if (cmd.advance) begin
      rd_addr = ptr + 1'b1;
    end else begin
      rd_addr = ptr;
    end
  end

  always_comb begin
    tick_entry = rd_data;
    if (rd_data.delay == '0) begin
      if (rd_data.pending != PEND_MAX) begin
        tick_entry.pending = rd_data.pending + 1'b1;
      end
      if (rd_data.period != '0) begin
        tick_entry.delay = rd_data.period;
      end
    end else begin
      tick_entry.delay = rd_data.delay - 1'b1;
    end
    disp_entry         = rd_data;
    disp_entry.pending = rd_data.pending - 1'b1;
  end

  always_comb begin
    wr_en = cmd.wr_tick | cmd.wr_add | cmd.wr_disp;
    if (cmd.wr_add) begin
      wr_data = '{tag: tag_q, delay: delay_q, period: period_q, pending: '0};
    end else if (cmd.wr_disp) begin
      wr_data = disp_entry;
    end else begin
      wr_data = tick_entry;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[ptr] <= wr_data;
    end
  end

  always_comb begin
    del_idx      = IDX_W'(sel_q);
    del_in_range = int'(sel_q) < MAX_TASKS;
    del_empty    = !del_in_range || !slot_valid[del_idx];
  end

  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      above[i] = i > int'(ptr);
    end
  end

  always_comb begin
    stat.op            = op_q;
    stat.at_end        = ptr == IDX_W'(MAX_TASKS - 1);
    stat.cur_valid     = slot_valid[ptr];
    stat.cur_runnable  = runnable[ptr];
    stat.more_runnable = |(runnable & above);
    stat.cnt_last      = cnt == CNT_W'(MAX_RES - 1);
    stat.out_free      = !out_valid || out_ready;
  end

  // Latch the request and position the scan.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= op_t'(op);
      tag_q    <= task_tag;
      delay_q  <= TIME_WIDTH'(start_delay);
      period_q <= TIME_WIDTH'(repeat_period);
      sel_q    <= slot_select;
      ptr      <= '0;
      cnt      <= '0;
    end else begin
      if (cmd.advance) begin
        ptr <= ptr + 1'b1;
      end
      if (cmd.wr_disp) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      runnable     <= '0;
      delete_error <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.wr_tick && rd_data.delay == '0) begin
        runnable[ptr] <= 1'b1;
      end
      if (cmd.wr_add) begin
        slot_valid[ptr] <= 1'b1;
        runnable[ptr]   <= 1'b0;
      end
      if (cmd.wr_disp) begin
        runnable[ptr] <= (rd_data.pending != PEND_W'(1)) && (rd_data.period != '0);
        // drop one-shot task after its run
        if (rd_data.period == '0) begin
          slot_valid[ptr] <= 1'b0;
        end
      end
      if (cmd.del_exec) begin
        if (del_in_range) begin
          slot_valid[del_idx] <= 1'b0;
          runnable[del_idx]   <= 1'b0;
        end
        if (del_empty) begin
          delete_error <= 1'b1;
        end
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      case (cmd.res_kind)
        RES_ADD: begin
          slot_index <= SLOT_W'(ptr);
          run_tag    <= '0;
          run_valid  <= 1'b0;
          status     <= STATUS_OK;
          error_seen <= delete_error;
          last       <= 1'b1;
        end
        RES_FULL: begin
          slot_index <= SLOT_W'(MAX_TASKS);
          run_tag    <= '0;
          run_valid  <= 1'b0;
          status     <= STATUS_FULL;
          error_seen <= delete_error;
          last       <= 1'b1;
        end
        RES_DEL: begin
          slot_index <= SLOT_W'(sel_q);
          run_tag    <= '0;
          run_valid  <= 1'b0;
          status     <= del_empty ? STATUS_EMPTY : STATUS_OK;
          error_seen <= delete_error | del_empty;
          last       <= 1'b1;
        end
        RES_RUN: begin
          slot_index <= SLOT_W'(ptr);
          run_tag    <= rd_data.tag;
          run_valid  <= 1'b1;
          status     <= STATUS_OK;
          error_seen <= delete_error;
          last       <= cmd.res_last;
        end
        default: begin
          slot_index <= '0;
          run_tag    <= '0;
          run_valid  <= 1'b0;
          status     <= STATUS_OK;
          error_seen <= delete_error;
          last       <= 1'b1;
        end
      endcase
    end
  end

  `TTS_ASSERT_IMPLY(a_push_free, clk, rst, cmd.push, stat.out_free, "result pushed while output busy")
  `TTS_ASSERT_IMPLY(a_add_free_slot, clk, rst, cmd.wr_add, !slot_valid[ptr], "add overwrote a live slot")
  `TTS_ASSERT_IMPLY(a_runnable_valid, clk, rst, 1'b1, (runnable & ~slot_valid) == '0, "empty slot marked pending")
  `TTS_ASSERT_NEXT(a_del_clears, clk, rst, cmd.del_exec && del_in_range, !slot_valid[$past(del_idx)], "deleted slot still valid")

endmodule

@@ design/tts_controller.sv @@
// Sequencer that walks the slot table for each tick, add or dispatch request.
module tts_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tts_pkg::op_t         in_op,
  input  tts_pkg::dp_status_t  stat,
  output tts_pkg::ctrl_cmd_t   cmd
);
  import tts_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.res_kind = RES_ADD;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = (in_op == OP_DELETE) ? ST_DEL : ST_SCAN;
        end
      end
      ST_DEL: begin
        if (stat.out_free) begin
          cmd.del_exec = 1'b1;
          cmd.push     = 1'b1;
          cmd.res_kind = RES_DEL;
          cmd.res_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_SCAN: begin
        case (stat.op)
          OP_TICK: begin
            cmd.wr_tick = stat.cur_valid;
            if (stat.at_end) begin
              state_next = ST_IDLE;
            end else begin
              cmd.advance = 1'b1;
            end
          end
          OP_ADD: begin
            if (!stat.cur_valid) begin
              // hold on this slot until the result register frees
              if (stat.out_free) begin
                cmd.wr_add   = 1'b1;
                cmd.push     = 1'b1;
                cmd.res_kind = RES_ADD;
                cmd.res_last = 1'b1;
                state_next   = ST_IDLE;
              end
            end else if (stat.at_end) begin
              if (stat.out_free) begin
                cmd.push     = 1'b1;
                cmd.res_kind = RES_FULL;
                cmd.res_last = 1'b1;
                state_next   = ST_IDLE;
              end
            end else begin
              cmd.advance = 1'b1;
            end
          end
          OP_DISPATCH: begin
            if (stat.cur_runnable) begin
              if (stat.out_free) begin
                cmd.wr_disp  = 1'b1;
                cmd.push     = 1'b1;
                cmd.res_kind = RES_RUN;
                cmd.res_last = stat.cnt_last || !stat.more_runnable;
                if (cmd.res_last || stat.at_end) begin
                  state_next = ST_IDLE;
                end else begin
                  cmd.advance = 1'b1;
                end
              end
            end else if (stat.at_end) begin
              state_next = ST_IDLE;
            end else begin
              cmd.advance = 1'b1;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/tick_task_scheduler.sv @@
// Tick task scheduler: tick, add, delete and dispatch over a slot table.
// Delete is not scanned: its result is registered once the result register is free. Tick, add
// and dispatch walk the slot memory one slot per cycle, add and dispatch stalling while the
// result register is full; a new request is taken only when the last one is done.
// Reset (rst, synchronous): all slots empty, error flag clear, no result waiting.
module tick_task_scheduler #(
  parameter int MAX_TASKS  = tts_pkg::MAX_TASKS_DEF,
  parameter int TIME_WIDTH = tts_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    op,
  input  logic [tts_pkg::TAG_W-1:0]     task_tag,
  input  logic [tts_pkg::FTIME_W-1:0]   start_delay,
  input  logic [tts_pkg::FTIME_W-1:0]   repeat_period,
  input  logic [tts_pkg::SEL_W-1:0]     slot_select,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tts_pkg::SLOT_W-1:0]    slot_index,
  output logic [tts_pkg::TAG_W-1:0]     run_tag,
  output logic                          run_valid,
  output logic [1:0]                    status,
  output logic                          error_seen,
  output logic                          last
);
  import tts_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  tts_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (op_t'(op)),
    .stat     (stat),
    .cmd      (cmd)
  );

  tts_datapath #(
    .MAX_TASKS  (MAX_TASKS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .task_tag      (task_tag),
    .start_delay   (start_delay),
    .repeat_period (repeat_period),
    .slot_select   (slot_select),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .slot_index    (slot_index),
    .run_tag       (run_tag),
    .run_valid     (run_valid),
    .status        (status),
    .error_seen    (error_seen),
    .last          (last)
  );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the tick task scheduler: slot table model, driver and monitor.
module tb_top;
  import tts_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_WAIT  = 4 * (MAX_TASKS_DEF + 2);
  localparam int RANDOM_COUNT = 105;
  localparam int SAT_TICKS    = 262;

  typedef struct packed {
    op_t                op;
    logic [TAG_W-1:0]   tag;
    logic [FTIME_W-1:0] delay;
    logic [FTIME_W-1:0] period;
    logic [SEL_W-1:0]   sel;
    bit                 hold;   // wait for all reports before sending
  } request_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic [TAG_W-1:0]  run_tag;
    logic              run_valid;
    logic [1:0]        status;
    logic              error_seen;
    logic              last;
  } report_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         op = OP_TICK;
  logic [TAG_W-1:0]   task_tag = '0;
  logic [FTIME_W-1:0] start_delay = '0;
  logic [FTIME_W-1:0] repeat_period = '0;
  logic [SEL_W-1:0]   slot_select = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [SLOT_W-1:0]  slot_index;
  logic [TAG_W-1:0]   run_tag;
  logic               run_valid;
  logic [1:0]         status;
  logic               error_seen;
  logic               last;

  tick_task_scheduler dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .task_tag      (task_tag),
    .start_delay   (start_delay),
    .repeat_period (repeat_period),
    .slot_select   (slot_select),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .slot_index    (slot_index),
    .run_tag       (run_tag),
    .run_valid     (run_valid),
    .status        (status),
    .error_seen    (error_seen),
    .last          (last)
  );

  always #5 clk = ~clk;

  // Slot table as the scheduler should hold it
  bit                 tbl_valid   [MAX_TASKS_DEF];
  logic [TAG_W-1:0]   tbl_tag     [MAX_TASKS_DEF];
  logic [FTIME_W-1:0] tbl_delay   [MAX_TASKS_DEF];
  logic [FTIME_W-1:0] tbl_period  [MAX_TASKS_DEF];
  logic [PEND_W-1:0]  tbl_pending [MAX_TASKS_DEF];
  bit                 tbl_error;

  request_t request_queue [$];
  report_t  pending_reports [$];
  request_t active_req;
  report_t  oldest_report;
  bit       in_taken;
  int       cycle_count;
  int       accepted;
  int       failures;
  int       checked;
  int       runs_seen;
  int       full_adds;
  int       empty_deletes;
  int       sat_ticks;

  // Long stretch with no idling on either side
  wire calm = (accepted >= 300) && (accepted < 380);

  function automatic request_t make_request(op_t o, int tag, int dly, int per, int sel,
                                            bit hold);
    request_t r;
    r.op     = o;
    r.tag    = tag[TAG_W-1:0];
    r.delay  = dly[FTIME_W-1:0];
    r.period = per[FTIME_W-1:0];
    r.sel    = sel[SEL_W-1:0];
    r.hold   = hold;
    return r;
  endfunction

  task automatic clear_slot(int s);
    tbl_valid[s]   = 1'b0;
    tbl_tag[s]     = '0;
    tbl_delay[s]   = '0;
    tbl_period[s]  = '0;
    tbl_pending[s] = '0;
  endtask

  // Update the slot table for one request and queue the reports it causes
  task automatic apply_to_slot_table(request_t r);
    int      s;
    int      n;
    report_t rep;
    rep = '0;
    n = 0;
    case (r.op)
      OP_TICK: begin
        for (s = 0; s < MAX_TASKS_DEF; s++) begin
          if (tbl_valid[s]) begin
            if (tbl_delay[s] == 0) begin
              if (tbl_pending[s] != PEND_MAX) tbl_pending[s]++;
              else sat_ticks++;
              if (tbl_period[s] != 0) tbl_delay[s] = tbl_period[s];
            end else begin
              tbl_delay[s]--;
            end
          end
        end
      end
      OP_ADD: begin
        s = 0;
        while (s < MAX_TASKS_DEF && tbl_valid[s]) s++;
        if (s == MAX_TASKS_DEF) begin
          rep.slot_index = SLOT_W'(MAX_TASKS_DEF);
          rep.status = STATUS_FULL;
          full_adds++;
        end else begin
          tbl_valid[s]   = 1'b1;
          tbl_tag[s]     = r.tag;
          tbl_delay[s]   = r.delay;
          tbl_period[s]  = r.period;
          tbl_pending[s] = '0;
          rep.slot_index = SLOT_W'(s);
          rep.status = STATUS_OK;
        end
        rep.error_seen = tbl_error;
        rep.last = 1'b1;
        pending_reports.push_back(rep);
      end
      OP_DELETE: begin
        rep.status = STATUS_OK;
        if (int'(r.sel) >= MAX_TASKS_DEF) begin
          rep.status = STATUS_EMPTY;
        end else begin
          if (!tbl_valid[r.sel]) rep.status = STATUS_EMPTY;
          clear_slot(int'(r.sel));
        end
        if (rep.status == STATUS_EMPTY) begin
          tbl_error = 1'b1;
          empty_deletes++;
        end
        rep.slot_index = SLOT_W'(r.sel);
        rep.error_seen = tbl_error;
        rep.last = 1'b1;
        pending_reports.push_back(rep);
      end
      default: begin
        for (s = 0; s < MAX_TASKS_DEF; s++) begin
          if (n < MAX_RES && tbl_valid[s] && tbl_pending[s] != 0) begin
            rep.slot_index = SLOT_W'(s);
            rep.run_tag    = tbl_tag[s];
            rep.run_valid  = 1'b1;
            rep.status     = STATUS_OK;
            rep.error_seen = tbl_error;
            rep.last       = 1'b0;
            pending_reports.push_back(rep);
            n++;
            tbl_pending[s]--;
            // one-shot task: drop it along with any remaining runs
            if (tbl_period[s] == 0) clear_slot(s);
          end
        end
        if (n > 0) begin
          rep = pending_reports.pop_back();
          rep.last = 1'b1;
          pending_reports.push_back(rep);
        end
      end
    endcase
  endtask

  // Driver: take the request at the rising edge, present the next one at the falling edge
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && in_valid && in_ready) begin
      apply_to_slot_table(active_req);
      in_taken = 1'b1;
      accepted++;
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        in_taken = 1'b0;
        if (request_queue.size() != 0 &&
            (!request_queue[0].hold || pending_reports.size() == 0) &&
            (calm || $urandom_range(99) >= 22)) begin
          active_req = request_queue.pop_front();
          in_valid      <= 1'b1;
          op            <= active_req.op;
          task_tag      <= active_req.tag;
          start_delay   <= active_req.delay;
          repeat_period <= active_req.period;
          slot_select   <= active_req.sel;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 22);
    end
  end

  // Monitor: compare each report with the oldest one predicted
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report: slot_index %0d run_tag %0d run_valid %0d status %0d",
               slot_index, run_tag, run_valid, status);
        failures++;
      end else begin
        oldest_report = pending_reports.pop_front();
        checked++;
        if (run_valid) runs_seen++;
        if (slot_index !== oldest_report.slot_index) begin
          $error("slot_index: expected %0d, got %0d", oldest_report.slot_index, slot_index);
          failures++;
        end
        if (run_tag !== oldest_report.run_tag) begin
          $error("run_tag: expected %0d, got %0d", oldest_report.run_tag, run_tag);
          failures++;
        end
        if (run_valid !== oldest_report.run_valid) begin
          $error("run_valid: expected %0d, got %0d", oldest_report.run_valid, run_valid);
          failures++;
        end
        if (status !== oldest_report.status) begin
          $error("status: expected %0d, got %0d", oldest_report.status, status);
          failures++;
        end
        if (error_seen !== oldest_report.error_seen) begin
          $error("error_seen: expected %0d, got %0d", oldest_report.error_seen, error_seen);
          failures++;
        end
        if (last !== oldest_report.last) begin
          $error("last: expected %0d, got %0d", oldest_report.last, last);
          failures++;
        end
      end
    end
  end

  initial begin : timeout_watch
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $error("timeout after %0d cycles, %0d requests left, %0d reports outstanding",
           cycle_count, request_queue.size(), pending_reports.size());
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int       i;
    int       k;
    int       pick;
    request_t r;

    for (i = 0; i < MAX_TASKS_DEF; i++) clear_slot(i);
    tbl_error = 1'b0;

    // Directed: empty table, fill to full, overflow, tick and dispatch, deletes
    request_queue.push_back(make_request(OP_DISPATCH, 0, 0, 0, 0, 0));
    request_queue.push_back(make_request(OP_DELETE, 0, 0, 0, 0, 0));
    request_queue.push_back(make_request(OP_ADD, 8'h00, 0, 0, 7, 0));
    request_queue.push_back(make_request(OP_ADD, 8'hff, 0, 1, 0, 0));
    request_queue.push_back(make_request(OP_ADD, 8'ha5, 1, 2, 0, 0));
    request_queue.push_back(make_request(OP_ADD, 8'h5a, 16'hffff, 16'hffff, 0, 0));
    request_queue.push_back(make_request(OP_ADD, 8'h01, 2, 0, 0, 0));
    request_queue.push_back(make_request(OP_ADD, 8'h80, 0, 3, 0, 0));
    request_queue.push_back(make_request(OP_ADD, 8'h7f, 3, 16'h8000, 0, 0));
    request_queue.push_back(make_request(OP_ADD, 8'h33, 0, 16'h7fff, 0, 0));
    request_queue.push_back(make_request(OP_ADD, 8'hff, 16'hffff, 16'hffff, 7, 0));
    request_queue.push_back(make_request(OP_TICK, 0, 0, 0, 0, 0));
    request_queue.push_back(make_request(OP_TICK, 8'hff, 16'hffff, 16'hffff, 7, 0));
    request_queue.push_back(make_request(OP_DISPATCH, 0, 0, 0, 0, 0));
    request_queue.push_back(make_request(OP_TICK, 0, 0, 0, 0, 0));
    request_queue.push_back(make_request(OP_TICK, 0, 0, 0, 0, 0));
    request_queue.push_back(make_request(OP_DISPATCH, 0, 0, 0, 0, 1));
    request_queue.push_back(make_request(OP_DELETE, 0, 0, 0, 7, 0));
    request_queue.push_back(make_request(OP_DELETE, 0, 0, 0, 7, 0));
    request_queue.push_back(make_request(OP_ADD, 8'h44, 0, 0, 0, 0));
    request_queue.push_back(make_request(OP_TICK, 0, 0, 0, 0, 0));
    request_queue.push_back(make_request(OP_DISPATCH, 0, 0, 0, 0, 0));
    request_queue.push_back(make_request(OP_DISPATCH, 0, 0, 0, 0, 0));

    // Saturate a pending count: empty the table, then tick well past 255
    for (i = 0; i < MAX_TASKS_DEF; i++)
      request_queue.push_back(make_request(OP_DELETE, 0, 0, 0, i, i == 0));
    request_queue.push_back(make_request(OP_ADD, 8'hc3, 0, 0, 0, 0));
    request_queue.push_back(make_request(OP_ADD, 8'h3c, 0, 1, 0, 0));
    for (i = 0; i < SAT_TICKS; i++)
      request_queue.push_back(make_request(OP_TICK, $urandom, $urandom, $urandom, $urandom, 0));
    for (i = 0; i < 3; i++)
      request_queue.push_back(make_request(OP_DISPATCH, 0, 0, 0, 0, 0));

    // Random mix with small delays and periods so tasks come due often
    for (i = 0; i < RANDOM_COUNT; i++) begin
      r = make_request(OP_TICK, $urandom, $urandom, $urandom, $urandom,
                       $urandom_range(39) == 0);
      k = $urandom_range(99);
      if (k < 38) begin
        r.op = OP_TICK;
      end else if (k < 60) begin
        r.op = OP_ADD;
        if ($urandom_range(9) != 0) r.delay = FTIME_W'($urandom_range(4));
        pick = $urandom_range(9);
        if (pick < 3) r.period = '0;
        else if (pick < 9) r.period = FTIME_W'($urandom_range(6, 1));
      end else if (k < 75) begin
        r.op = OP_DELETE;
      end else begin
        r.op = OP_DISPATCH;
      end
      request_queue.push_back(r);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_queue.size() != 0 || in_valid) @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);

    $display("Ran %0d requests; checked %0d reports, %0d of them task runs.",
             accepted, checked, runs_seen);
    $display("Saw %0d full-table adds, %0d empty deletes, %0d saturated pending ticks.",
             full_adds, empty_deletes, sat_ticks);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
